/* hw/rtl/pidc_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, widths and saturation helpers of the PID step block.
// Depends on nothing; every other file of the block imports it.
package pidc_pkg;

	localparam int W    = 32;           // data word
	localparam int FRAC = 16;           // fraction bits of Q16.16
	localparam int DTW  = 31;           // step time width
	localparam int MW   = W + 1;        // serial multiplier operand width
	localparam int PW   = 2 * MW + 1;   // serial multiplier product width
	localparam int NW   = W + FRAC;     // divider numerator width
	localparam int IW   = 3;            // config index width

	localparam logic [IW-1:0] REG_GAIN_P        = 3'd0;
	localparam logic [IW-1:0] REG_GAIN_I        = 3'd1;
	localparam logic [IW-1:0] REG_GAIN_D        = 3'd2;
	localparam logic [IW-1:0] REG_DRIVE_FLOOR   = 3'd3;
	localparam logic [IW-1:0] REG_DRIVE_CEILING = 3'd4;
	localparam logic [IW-1:0] REG_ACCUM_FLOOR   = 3'd5;
	localparam logic [IW-1:0] REG_ACCUM_CEILING = 3'd6;

	localparam logic OP_COMPUTE = 1'b0;
	localparam logic OP_RESET   = 1'b1;

	localparam logic [W-1:0] WORD_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] WORD_MIN = {1'b1, {(W-1){1'b0}}};

	// Floor-shift a full product by FRAC and saturate it to one word.
	function automatic logic [W-1:0] sat_prod(input logic [PW-1:0] p);
		logic [PW-FRAC-1:0] s;
		logic               ovf;
		s   = p[PW-1:FRAC];
		ovf = !((&s[PW-FRAC-1:W-1]) || !(|s[PW-FRAC-1:W-1]));
		if (ovf)
			sat_prod = s[PW-FRAC-1] ? WORD_MIN : WORD_MAX;
		else
			sat_prod = s[W-1:0];
	endfunction

	// Saturate a value one bit wider than a word.
	function automatic logic [W-1:0] sat_wide(input logic [W:0] v);
		if (v[W] != v[W-1])
			sat_wide = v[W] ? WORD_MIN : WORD_MAX;
		else
			sat_wide = v[W-1:0];
	endfunction

endpackage

/* hw/rtl/pid_controller_step_top.sv */
`timescale 1ns / 1ps
// Top level of the PID step block: config registers, sequencer, loop state.
// Depends on pidc_pkg, pidc_mul and pidc_div.

// Positional PID step in signed Q16.16. A compute item reaches the output
// register through these steps: a setup state for the error, a start state
// and a wait for three bit-serial multipliers (error times step time,
// proportional and derivative products), an accumulator update state, a
// start state and a wait in which the restoring divider forms the derivative
// quotient while one multiplier forms the integral term, a sum-and-clamp
// state and a hand-off state. The divider forms one bit per cycle over 48
// bits. After the hand-off the sequencer returns to idle and takes the next
// item. A reset item goes from acceptance straight to the hand-off state.
// Items are taken one at a time; a finished result sits in the output
// register while the next item is accepted, and a result that cannot be
// handed off holds the input. Config writes are always ready.
module pid_controller_step_top import pidc_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [IW-1:0]  cfg_index,
	input  logic [W-1:0]   cfg_data,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           op,
	input  logic [W-1:0]   reference,
	input  logic [W-1:0]   measurement,
	input  logic [DTW-1:0] step_time,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [W-1:0]   drive,
	output logic           clamped
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_PREP   = 4'd1;
	localparam logic [3:0] S_MULA   = 4'd2;
	localparam logic [3:0] S_MULA_W = 4'd3;
	localparam logic [3:0] S_ACC    = 4'd4;
	localparam logic [3:0] S_MULB   = 4'd5;
	localparam logic [3:0] S_MULB_W = 4'd6;
	localparam logic [3:0] S_SUM    = 4'd7;
	localparam logic [3:0] S_DONE   = 4'd8;

	logic [3:0]     state_q;

	// config registers
	logic [W-1:0]   gain_p_q, gain_i_q, gain_d_q;
	logic [W-1:0]   drive_floor_q, drive_ceiling_q;
	logic [W-1:0]   accum_floor_q, accum_ceiling_q;

	// loop state
	logic [W-1:0]   acc_q;
	logic [W-1:0]   last_err_q;
	logic           first_q;

	// per-item working registers
	logic [W-1:0]   ref_q, meas_q, err_q;
	logic [DTW-1:0] dt_q;
	logic [W-1:0]   p_q, dprod_q;
	logic           dflag_q;
	logic [W-1:0]   res_drive_q;
	logic           res_clamped_q;
	logic           out_valid_q;
	logic [W-1:0]   drive_q;
	logic           clamped_q;

	logic           mul_start_a, mul_start_b, div_start;
	logic [MW-1:0]  m0_a, m0_b, m1_a, m1_b, m2_a, m2_b;
	logic [PW-1:0]  m0_p, m1_p, m2_p;
	logic           m0_busy, m1_busy, m2_busy, div_busy;
	logic [W-1:0]   div_q;
	logic           accept, out_free, dt_nz;

	logic [W:0]     err_wide;
	logic [W:0]     isum_wide;
	logic [W-1:0]   acc_next;
	logic [W-1:0]   i_term, d_term;
	logic [W+1:0]   sum, drive_next;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign dt_nz     = |dt_q;

	// Hold config writes; drop indexes beyond the list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q        <= '0;
			gain_i_q        <= '0;
			gain_d_q        <= '0;
			drive_floor_q   <= WORD_MIN;
			drive_ceiling_q <= WORD_MAX;
			accum_floor_q   <= WORD_MIN;
			accum_ceiling_q <= WORD_MAX;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_GAIN_P:        gain_p_q        <= cfg_data;
				REG_GAIN_I:        gain_i_q        <= cfg_data;
				REG_GAIN_D:        gain_d_q        <= cfg_data;
				REG_DRIVE_FLOOR:   drive_floor_q   <= cfg_data;
				REG_DRIVE_CEILING: drive_ceiling_q <= cfg_data;
				REG_ACCUM_FLOOR:   accum_floor_q   <= cfg_data;
				REG_ACCUM_CEILING: accum_ceiling_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Multiplier operands: phase A uses all three, phase B reuses unit 0
	// for the integral gain times the freshly clamped accumulator.
	assign mul_start_a = (state_q == S_MULA);
	assign mul_start_b = (state_q == S_MULB);
	assign div_start   = mul_start_b && dflag_q;

	always_comb begin
		if (state_q == S_MULB || state_q == S_MULB_W) begin
			m0_a = {gain_i_q[W-1], gain_i_q};
			m0_b = {acc_q[W-1], acc_q};
		end else begin
			m0_a = {err_q[W-1], err_q};
			m0_b = {2'b00, dt_q};
		end
		m1_a = {gain_p_q[W-1], gain_p_q};
		m1_b = {err_q[W-1], err_q};
		m2_a = {gain_d_q[W-1], gain_d_q};
		m2_b = {err_q[W-1], err_q} - {last_err_q[W-1], last_err_q};
	end

	pidc_mul u_mul0 (.clk, .arst_n, .start(mul_start_a || mul_start_b),
		.a(m0_a), .b(m0_b), .busy(m0_busy), .product(m0_p));
	pidc_mul u_mul1 (.clk, .arst_n, .start(mul_start_a),
		.a(m1_a), .b(m1_b), .busy(m1_busy), .product(m1_p));
	pidc_mul u_mul2 (.clk, .arst_n, .start(mul_start_a),
		.a(m2_a), .b(m2_b), .busy(m2_busy), .product(m2_p));

	pidc_div u_div (.clk, .arst_n, .start(div_start),
		.num({dprod_q, {FRAC{1'b0}}}), .den(dt_q), .busy(div_busy),
		.quotient(div_q));

	// Error, accumulator update and final sum with clamps. Unit 0's scaled
	// product is the error-times-step-time increment in S_ACC and the
	// integral term in S_SUM.
	always_comb begin
		err_wide  = {ref_q[W-1], ref_q} - {meas_q[W-1], meas_q};
		i_term    = sat_prod(m0_p);
		isum_wide = {acc_q[W-1], acc_q} + {i_term[W-1], i_term};
		acc_next  = sat_wide(isum_wide);
		if ($signed(acc_next) > $signed(accum_ceiling_q))
			acc_next = accum_ceiling_q;
		if ($signed(acc_next) < $signed(accum_floor_q))
			acc_next = accum_floor_q;

		d_term = dflag_q ? div_q : '0;
		sum    = {{2{p_q[W-1]}}, p_q} + {{2{i_term[W-1]}}, i_term}
			+ {{2{d_term[W-1]}}, d_term};
		drive_next = sum;
		if ($signed(drive_next) > $signed({{2{drive_ceiling_q[W-1]}}, drive_ceiling_q}))
			drive_next = {{2{drive_ceiling_q[W-1]}}, drive_ceiling_q};
		if ($signed(drive_next) < $signed({{2{drive_floor_q[W-1]}}, drive_floor_q}))
			drive_next = {{2{drive_floor_q[W-1]}}, drive_floor_q};
	end

	// Sequencer and loop state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			acc_q      <= '0;
			last_err_q <= '0;
			first_q    <= 1'b1;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (op == OP_RESET) begin
							acc_q      <= '0;
							last_err_q <= '0;
							first_q    <= 1'b1;
							state_q    <= S_DONE;
						end else begin
							state_q <= S_PREP;
						end
					end
				end
				S_PREP:   state_q <= S_MULA;
				S_MULA:   state_q <= S_MULA_W;
				S_MULA_W: if (!m0_busy && !m1_busy && !m2_busy) state_q <= S_ACC;
				S_ACC: begin
					if (dt_nz)
						acc_q <= acc_next;
					last_err_q <= err_q;
					first_q    <= 1'b0;
					state_q    <= S_MULB;
				end
				S_MULB:   state_q <= S_MULB_W;
				S_MULB_W: if (!m0_busy && !div_busy) state_q <= S_SUM;
				S_SUM:    state_q <= S_DONE;
				S_DONE:   if (out_free) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers (no reset needed).
	always_ff @(posedge clk) begin
		if (accept) begin
			ref_q  <= reference;
			meas_q <= measurement;
			dt_q   <= step_time;
		end
		if (accept && op == OP_RESET) begin
			res_drive_q   <= '0;
			res_clamped_q <= 1'b0;
		end
		if (state_q == S_PREP)
			err_q <= sat_wide(err_wide);
		if (state_q == S_ACC) begin
			p_q     <= sat_prod(m1_p);
			dprod_q <= sat_prod(m2_p);
			dflag_q <= !first_q && dt_nz;
		end
		if (state_q == S_SUM) begin
			res_drive_q   <= drive_next[W-1:0];
			res_clamped_q <= (drive_next != sum);
		end
		if (state_q == S_DONE && out_free) begin
			drive_q   <= res_drive_q;
			clamped_q <= res_clamped_q;
		end
	end

	// Output register: load from the result stage, drop on take.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == S_DONE && out_free)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign clamped   = clamped_q;

	a_div_phase: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> (state_q == S_MULB_W))
		else $error("divider running outside the second pass");

	a_mul_phase: assert property (@(posedge clk) disable iff (!arst_n)
		m0_busy |-> (state_q == S_MULA_W || state_q == S_MULB_W))
		else $error("multiplier running outside a pass");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_DONE))
		else $error("result loaded outside the done state");

	a_clamp_lim: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && clamped_q) |->
		(drive_q == drive_floor_q || drive_q == drive_ceiling_q))
		else $error("clamped result not at a drive limit");

endmodule

/* hw/rtl/pidc_mul.sv */
`timescale 1ns / 1ps
// Bit-serial signed multiplier: one multiplier bit per cycle.
// Depends on pidc_pkg.
module pidc_mul import pidc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [MW-1:0] a,
	input  logic [MW-1:0] b,
	output logic          busy,
	output logic [PW-1:0] product
);

	logic [MW:0]   h_q;
	logic [MW-1:0] l_q;
	logic [MW-1:0] a_q;
	logic [5:0]    cnt_q;
	logic          busy_q;
	logic [MW:0]   addend;
	logic [MW+1:0] sum;
	logic          last;

	assign last = (cnt_q == 6'(MW - 1));

	always_comb begin
		addend = '0;
		if (l_q[0]) begin
			if (last)
				addend = -{a_q[MW-1], a_q};
			else
				addend = {a_q[MW-1], a_q};
		end
		sum = {h_q[MW], h_q} + {addend[MW], addend};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (last)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			h_q <= '0;
			l_q <= b;
			a_q <= a;
		end else if (busy_q) begin
			h_q <= sum[MW+1:1];
			l_q <= {sum[0], l_q[MW-1:1]};
		end
	end

	assign busy    = busy_q;
	assign product = {h_q, l_q};

endmodule

/* hw/rtl/pidc_div.sv */
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, truncating toward zero,
// quotient saturated to one word. Depends on pidc_pkg.
module pidc_div import pidc_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [NW-1:0]  num,
	input  logic [DTW-1:0] den,
	output logic           busy,
	output logic [W-1:0]   quotient
);

	logic [DTW-1:0] rem_q;
	logic [NW-1:0]  quo_q;
	logic [DTW-1:0] den_q;
	logic           neg_q;
	logic [5:0]     cnt_q;
	logic           busy_q;
	logic [DTW:0]   shifted;
	logic [DTW+1:0] diff;
	logic           ge;

	assign shifted = {rem_q, quo_q[NW-1]};
	assign diff    = {1'b0, shifted} - {2'b00, den_q};
	assign ge      = !diff[DTW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'(NW - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num[NW-1] ? -num : num;
			neg_q <= num[NW-1];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DTW-1:0] : shifted[DTW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	always_comb begin
		if (neg_q) begin
			if ((|quo_q[NW-1:W]) || (quo_q[W-1] && (|quo_q[W-2:0])))
				quotient = WORD_MIN;
			else
				quotient = -quo_q[W-1:0];
		end else begin
			if ((|quo_q[NW-1:W]) || quo_q[W-1])
				quotient = WORD_MAX;
			else
				quotient = quo_q[W-1:0];
		end
	end

	assign busy = busy_q;

endmodule
